/* src/rrcc_pkg.sv */
// Shared types, constants and codes for the RGB ratio color classifier.
// Depends on nothing; used by rrcc_div, rgb_ratio_color_classifier and the bench.
`timescale 1ns / 1ps

package rrcc_pkg;

   // Sample and ratio formats
   localparam int SAMPLE_BITS     = 10;
   localparam int RATIO_FRAC_BITS = 8;
   localparam int RATIO_INT_BITS  = 8;
   localparam int QUOT_W          = RATIO_INT_BITS + RATIO_FRAC_BITS;
   localparam int OPND_W          = (SAMPLE_BITS + 1 > QUOT_W) ? SAMPLE_BITS + 1 : QUOT_W;
   localparam int CNT_W           = $clog2(QUOT_W);
   localparam logic [QUOT_W-1:0] RMAX = {QUOT_W{1'b1}};

   // Configuration register formats
   localparam int BRIGHT_W  = 10;
   localparam int THR_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int CMP_W     = (QUOT_W > THR_W) ? QUOT_W : THR_W;
   localparam int BRT_CMP_W = (SAMPLE_BITS > BRIGHT_W) ? SAMPLE_BITS : BRIGHT_W;

   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RED    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_YELLOW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND = 3'd5;

   localparam logic [THR_W-1:0] THR_RESET = 16'd256;

   // Floor(4x/5) by reciprocal multiply; exact for x below 2^SCALE_SHIFT / 4
   localparam int SCALE_SHIFT = SAMPLE_BITS + 4;
   localparam int SCALE_M_W   = SCALE_SHIFT - 2;
   localparam int SCALE_X_W   = SAMPLE_BITS + 2;
   localparam int SCALE_P_W   = SCALE_X_W + SCALE_M_W;
   localparam logic [SCALE_M_W-1:0] SCALE_MULT = SCALE_M_W'(((1 << SCALE_SHIFT) + 4) / 5);

   // Item kinds
   localparam logic REQ_RESTART  = 1'b0;
   localparam logic REQ_CLASSIFY = 1'b1;

   // Result classes
   localparam logic [2:0] CLASS_OTHER  = 3'd0;
   localparam logic [2:0] CLASS_RED    = 3'd1;
   localparam logic [2:0] CLASS_GREEN  = 3'd2;
   localparam logic [2:0] CLASS_BLUE   = 3'd3;
   localparam logic [2:0] CLASS_YELLOW = 3'd4;

   // Candidate index (first ratios)
   localparam logic [1:0] PICK_RED    = 2'd0;
   localparam logic [1:0] PICK_GREEN  = 2'd1;
   localparam logic [1:0] PICK_BLUE   = 2'd2;
   localparam logic [1:0] PICK_YELLOW = 2'd3;

   // Division sequence
   localparam logic [2:0] OP_RED    = 3'd0;
   localparam logic [2:0] OP_GREEN  = 3'd1;
   localparam logic [2:0] OP_BLUE   = 3'd2;
   localparam logic [2:0] OP_YELLOW = 3'd3;
   localparam logic [2:0] OP_SECOND = 3'd4;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [QUOT_W-1:0]      ratio_type;
   typedef logic [OPND_W-1:0]      opnd_type;

   typedef struct packed {
      sample_type r;
      sample_type g;
      sample_type b;
   } rgb_type;

   typedef struct packed {
      logic     start;
      opnd_type num;
      opnd_type den;
   } div_req_type;

   typedef struct packed {
      logic      done;
      ratio_type quot;
   } div_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT,
      ST_OUTPUT
   } ctrl_state_type;

endpackage

/* src/rrcc_div.sv */
// Shared saturating fixed-point divider, one quotient bit per cycle.
// Depends on rrcc_pkg.
`timescale 1ns / 1ps

module rrcc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rrcc_pkg::div_req_type div_req,
   output rrcc_pkg::div_rsp_type div_rsp
);
   import rrcc_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   opnd_type         rem_ff, rem_in;
   opnd_type         den_ff, den_in;
   ratio_type        bits_ff, bits_in;
   ratio_type        quo_ff, quo_in;

   opnd_type         num_hi;
   logic             sat;
   logic [OPND_W:0]  shifted;
   logic [OPND_W:0]  diff;
   logic             fits;

   always_comb begin
      // quotient overflows when num >= 2^INT_BITS * den
      num_hi  = {{RATIO_INT_BITS{1'b0}}, div_req.num[OPND_W-1:RATIO_INT_BITS]};
      sat     = (div_req.den == '0) || (num_hi >= div_req.den);
      shifted = {rem_ff, bits_ff[QUOT_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;

      if (div_req.start) begin
         den_in  = div_req.den;
         rem_in  = num_hi;
         bits_in = {div_req.num[RATIO_INT_BITS-1:0], {RATIO_FRAC_BITS{1'b0}}};
         cnt_in  = '0;
         if (sat) begin
            quo_in  = RMAX;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         // restoring step: shift in next dividend bit, subtract if it fits
         rem_in  = fits ? diff[OPND_W-1:0] : shifted[OPND_W-1:0];
         quo_in  = {quo_ff[QUOT_W-2:0], fits};
         bits_in = {bits_ff[QUOT_W-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

/* src/rgb_ratio_color_classifier.sv */
// RGB ratio color classifier top level: sample history, sequencer, decision.
// Depends on rrcc_pkg and rrcc_div.
`timescale 1ns / 1ps

// Each classify item runs five divisions in turn on one shared restoring
// divider (red, green, blue and yellow ratios, then the second ratio of the
// winning candidate). A saturating division returns RMAX without any
// quotient bit steps; otherwise the divider gives one quotient bit per
// cycle. The input channel stalls from accept until the result item has
// been taken. A restart item is absorbed without a stall and gives no
// result. Configuration writes land at once and are meant for idle time.
module rgb_ratio_color_classifier (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_type,
   input  rrcc_pkg::sample_type    req_red_in,
   input  rrcc_pkg::sample_type    req_green_in,
   input  rrcc_pkg::sample_type    req_blue_in,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_color_class,
   output rrcc_pkg::sample_type    rsp_sel_red,
   output rrcc_pkg::sample_type    rsp_sel_green,
   output rrcc_pkg::sample_type    rsp_sel_blue,

   input  logic                    csr_write,
   input  logic [rrcc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rrcc_pkg::CSR_DAT_W-1:0] csr_data
);
   import rrcc_pkg::*;

   // configuration registers
   logic [BRIGHT_W-1:0] bright_thr_ff;
   logic [THR_W-1:0]    red_thr_ff, green_thr_ff, blue_thr_ff, yellow_thr_ff;
   logic [THR_W-1:0]    second_thr_ff;

   // sequencer and datapath state
   ctrl_state_type state_ff, state_in;
   rgb_type        hist_ff [3];
   rgb_type        hist_in [3];
   sample_type     r_ff, r_in, g_ff, g_in, b_ff, b_in;
   ratio_type      ratio_ff [4];
   ratio_type      ratio_in [4];
   logic [2:0]     op_ff, op_in;
   logic [1:0]     best_ff, best_in;
   logic [2:0]     cls_ff, cls_in;

   // combinational helpers
   logic                  req_accept;
   logic [SCALE_X_W-1:0]  scale_x;
   logic [SCALE_P_W-1:0]  scale_p;
   sample_type            scaled_blue;
   logic [1:0]            best_now;
   sample_type            max_rgb;
   logic [THR_W-1:0]      thr_sel;
   logic [2:0]            cls_pick;
   logic                  bright_ok, ratio_ok, second_ok;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   rrcc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Hold configuration; ignore writes beyond the last register
   always_ff @(posedge clock) begin
      if (reset) begin
         bright_thr_ff <= '0;
         red_thr_ff    <= THR_RESET;
         green_thr_ff  <= THR_RESET;
         blue_thr_ff   <= THR_RESET;
         yellow_thr_ff <= THR_RESET;
         second_thr_ff <= THR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BRIGHT: bright_thr_ff <= csr_data[BRIGHT_W-1:0];
            CSR_RED:    red_thr_ff    <= csr_data[THR_W-1:0];
            CSR_GREEN:  green_thr_ff  <= csr_data[THR_W-1:0];
            CSR_BLUE:   blue_thr_ff   <= csr_data[THR_W-1:0];
            CSR_YELLOW: yellow_thr_ff <= csr_data[THR_W-1:0];
            CSR_SECOND: second_thr_ff <= csr_data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Scale incoming blue by 4/5, floored, via reciprocal multiply
   always_comb begin
      scale_x     = {req_blue_in, 2'b00};
      scale_p     = SCALE_P_W'(scale_x) * SCALE_P_W'(SCALE_MULT);
      scaled_blue = scale_p[SCALE_SHIFT +: SAMPLE_BITS];
   end

   // Argmax over the first ratios; first one wins on ties
   always_comb begin
      best_now = PICK_RED;
      if (ratio_ff[1] > ratio_ff[0]) best_now = PICK_GREEN;
      if (ratio_ff[2] > ratio_ff[best_now]) best_now = PICK_BLUE;
      if (ratio_ff[3] > ratio_ff[best_now]) best_now = PICK_YELLOW;
   end

   // Divider operands for the current step
   always_comb begin
      div_req.start = (state_ff == ST_LAUNCH);
      case (op_ff)
         OP_RED: begin
            div_req.num = OPND_W'({r_ff, 1'b0});
            div_req.den = OPND_W'(g_ff) + OPND_W'(b_ff);
         end
         OP_GREEN: begin
            div_req.num = OPND_W'({g_ff, 1'b0});
            div_req.den = OPND_W'(r_ff) + OPND_W'(b_ff);
         end
         OP_BLUE: begin
            div_req.num = OPND_W'({b_ff, 1'b0});
            div_req.den = OPND_W'(r_ff) + OPND_W'(g_ff);
         end
         OP_YELLOW: begin
            div_req.num = OPND_W'(r_ff) + OPND_W'(g_ff);
            div_req.den = OPND_W'({b_ff, 1'b0});
         end
         default: begin
            // second ratio of the winning candidate
            case (best_now)
               PICK_RED: begin
                  div_req.num = OPND_W'(ratio_ff[0]);
                  div_req.den = OPND_W'(ratio_ff[3]);
               end
               PICK_GREEN: begin
                  div_req.num = OPND_W'(ratio_ff[1]);
                  div_req.den = OPND_W'(ratio_ff[3]);
               end
               PICK_BLUE: begin
                  div_req.num = OPND_W'(ratio_ff[2]);
                  div_req.den = OPND_W'(ratio_ff[1]);
               end
               default: begin
                  div_req.num = OPND_W'(ratio_ff[3]);
                  div_req.den = OPND_W'(ratio_ff[0]);
               end
            endcase
         end
      endcase
   end

   // Decision terms, evaluated when the second ratio comes back
   always_comb begin
      max_rgb = r_ff;
      if (g_ff > max_rgb) max_rgb = g_ff;
      if (b_ff > max_rgb) max_rgb = b_ff;

      case (best_ff)
         PICK_RED: begin
            thr_sel  = red_thr_ff;
            cls_pick = CLASS_RED;
         end
         PICK_GREEN: begin
            thr_sel  = green_thr_ff;
            cls_pick = CLASS_GREEN;
         end
         PICK_BLUE: begin
            thr_sel  = blue_thr_ff;
            cls_pick = CLASS_BLUE;
         end
         default: begin
            thr_sel  = yellow_thr_ff;
            cls_pick = CLASS_YELLOW;
         end
      endcase

      bright_ok = BRT_CMP_W'(max_rgb) > BRT_CMP_W'(bright_thr_ff);
      ratio_ok  = CMP_W'(ratio_ff[best_ff]) >= CMP_W'(thr_sel);
      second_ok = CMP_W'(div_rsp.quot) > CMP_W'(second_thr_ff);
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in = state_ff;
      hist_in  = hist_ff;
      r_in     = r_ff;
      g_in     = g_ff;
      b_in     = b_ff;
      ratio_in = ratio_ff;
      op_in    = op_ff;
      best_in  = best_ff;
      cls_in   = cls_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_type == REQ_RESTART) begin
                  // fill the whole history with the unscaled sample
                  hist_in[0] = '{r: req_red_in, g: req_green_in, b: req_blue_in};
                  hist_in[1] = hist_in[0];
                  hist_in[2] = hist_in[0];
               end else begin
                  // push; pick working color from three history depths
                  hist_in[0] = '{r: req_red_in, g: req_green_in, b: scaled_blue};
                  hist_in[1] = hist_ff[0];
                  hist_in[2] = hist_ff[1];
                  r_in       = req_green_in;
                  g_in       = hist_ff[0].r;
                  b_in       = hist_ff[1].b;
                  op_in      = OP_RED;
                  state_in   = ST_LAUNCH;
               end
            end
         end
         ST_LAUNCH: begin
            if (op_ff == OP_SECOND) begin
               best_in = best_now;
            end
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               if (op_ff == OP_SECOND) begin
                  cls_in   = (bright_ok && ratio_ok && second_ok) ? cls_pick : CLASS_OTHER;
                  state_in = ST_OUTPUT;
               end else begin
                  ratio_in[op_ff[1:0]] = div_rsp.quot;
                  op_in    = op_ff + 3'd1;
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_OUTPUT: begin
            // hold the result until taken
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < 3; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         hist_ff  <= hist_in;
      end
      r_ff     <= r_in;
      g_ff     <= g_in;
      b_ff     <= b_in;
      ratio_ff <= ratio_in;
      op_ff    <= op_in;
      best_ff  <= best_in;
      cls_ff   <= cls_in;
   end

   assign rsp_valid       = (state_ff == ST_OUTPUT);
   assign rsp_color_class = cls_ff;
   assign rsp_sel_red     = r_ff;
   assign rsp_sel_green   = g_ff;
   assign rsp_sel_blue    = b_ff;

endmodule

/* bench/color_result_checker.sv */
// Result checker for the RGB ratio color classifier bench: watches both channels,
// keeps its own sample history and thresholds, predicts each result and compares.
// Depends on rrcc_pkg.
`timescale 1ns / 1ps

module color_result_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_type,
   input  rrcc_pkg::sample_type                 req_red_in,
   input  rrcc_pkg::sample_type                 req_green_in,
   input  rrcc_pkg::sample_type                 req_blue_in,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [2:0]                           rsp_color_class,
   input  rrcc_pkg::sample_type                 rsp_sel_red,
   input  rrcc_pkg::sample_type                 rsp_sel_green,
   input  rrcc_pkg::sample_type                 rsp_sel_blue,
   input  logic                                 csr_write,
   input  logic [rrcc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rrcc_pkg::CSR_DAT_W-1:0]       csr_data,
   output int                                   outstanding,
   output int                                   fail_count
);
   import rrcc_pkg::*;

   typedef struct packed {
      logic [2:0] color;
      rgb_type    sel;
   } color_result_type;

   rgb_type             history [3];      // [0] newest, [2] oldest
   logic [BRIGHT_W-1:0] bright_limit;
   logic [THR_W-1:0]    ratio_limit [4];  // indexed by candidate
   logic [THR_W-1:0]    second_limit;
   color_result_type    expected_colors [$];
   int                  errors = 0;

   // Floored Q8.8 quotient, saturated; a zero divisor stands for infinity
   function automatic ratio_type sat_quotient(input logic [31:0] num, input logic [31:0] den);
      logic [47:0] q;
      if (den == 0)
         return RMAX;
      q = {16'd0, num} << RATIO_FRAC_BITS;
      q = q / {16'd0, den};
      return (q > {32'd0, RMAX}) ? RMAX : q[QUOT_W-1:0];
   endfunction

   task automatic absorb_sample(input logic kind, input sample_type red, green, blue);
      rgb_type          s;
      logic [31:0]      r, g, b, brightest;
      ratio_type        first [4];
      ratio_type        second [4];
      int               best;
      color_result_type res;
      s.r = red;
      s.g = green;
      s.b = blue;
      if (kind == REQ_RESTART) begin
         // restart keeps blue unscaled in every entry
         for (int i = 0; i < 3; i++)
            history[i] = s;
      end else begin
         s.b = sample_type'((32'(blue) * 4) / 5);
         history[2] = history[1];
         history[1] = history[0];
         history[0] = s;
         r = 32'(history[0].g);
         g = 32'(history[1].r);
         b = 32'(history[2].b);

         first[PICK_RED]    = sat_quotient(2 * r, g + b);
         first[PICK_GREEN]  = sat_quotient(2 * g, r + b);
         first[PICK_BLUE]   = sat_quotient(2 * b, r + g);
         first[PICK_YELLOW] = sat_quotient(r + g, 2 * b);
         second[PICK_RED]    = sat_quotient(32'(first[PICK_RED]), 32'(first[PICK_YELLOW]));
         second[PICK_GREEN]  = sat_quotient(32'(first[PICK_GREEN]), 32'(first[PICK_YELLOW]));
         second[PICK_BLUE]   = sat_quotient(32'(first[PICK_BLUE]), 32'(first[PICK_GREEN]));
         second[PICK_YELLOW] = sat_quotient(32'(first[PICK_YELLOW]), 32'(first[PICK_RED]));

         // strict compare: the earlier candidate wins a tie
         best = 0;
         for (int i = 1; i < 4; i++)
            if (first[i] > first[best])
               best = i;

         brightest = r;
         if (g > brightest)
            brightest = g;
         if (b > brightest)
            brightest = b;

         res.color = CLASS_OTHER;
         if (brightest > 32'(bright_limit) && first[best] >= ratio_limit[best] &&
             second[best] > second_limit) begin
            case (best)
               PICK_RED:    res.color = CLASS_RED;
               PICK_GREEN:  res.color = CLASS_GREEN;
               PICK_BLUE:   res.color = CLASS_BLUE;
               default:     res.color = CLASS_YELLOW;
            endcase
         end
         res.sel.r = r[SAMPLE_BITS-1:0];
         res.sel.g = g[SAMPLE_BITS-1:0];
         res.sel.b = b[SAMPLE_BITS-1:0];
         expected_colors.push_back(res);
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   task automatic compare_result();
      color_result_type want;
      if (expected_colors.size() == 0) begin
         errors++;
         $display("%0t: result with none expected: class %0d rgb %0d %0d %0d", $time,
                  rsp_color_class, rsp_sel_red, rsp_sel_green, rsp_sel_blue);
      end else begin
         want = expected_colors.pop_front();
         check_field("color_class", int'(want.color), int'(rsp_color_class));
         check_field("sel_red", int'(want.sel.r), int'(rsp_sel_red));
         check_field("sel_green", int'(want.sel.g), int'(rsp_sel_green));
         check_field("sel_blue", int'(want.sel.b), int'(rsp_sel_blue));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++)
            history[i] = '0;
         bright_limit = '0;
         for (int i = 0; i < 4; i++)
            ratio_limit[i] = THR_RESET;
         second_limit = THR_RESET;
         expected_colors.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_BRIGHT: bright_limit = csr_data[BRIGHT_W-1:0];
               CSR_RED:    ratio_limit[PICK_RED] = csr_data;
               CSR_GREEN:  ratio_limit[PICK_GREEN] = csr_data;
               CSR_BLUE:   ratio_limit[PICK_BLUE] = csr_data;
               CSR_YELLOW: ratio_limit[PICK_YELLOW] = csr_data;
               CSR_SECOND: second_limit = csr_data;
               default:    ;
            endcase
         end
         if (req_valid && !req_stall)
            absorb_sample(req_type, req_red_in, req_green_in, req_blue_in);
         if (rsp_valid && !rsp_stall)
            compare_result();
      end
      outstanding <= expected_colors.size();
      fail_count  <= errors;
   end

endmodule

/* bench/testbench.sv */
// Top of the RGB ratio color classifier bench: clock, reset, stimulus and verdict.
// Depends on rrcc_pkg, rgb_ratio_color_classifier and color_result_checker.
`timescale 1ns / 1ps

module testbench;
   import rrcc_pkg::*;

   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 129;
   // Wait this long before touching registers
   localparam int SETTLE_CYCLES   = 120;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 3000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_type = REQ_RESTART;
   sample_type           req_red_in = '0;
   sample_type           req_green_in = '0;
   sample_type           req_blue_in = '0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [2:0]           rsp_color_class;
   sample_type           rsp_sel_red;
   sample_type           rsp_sel_green;
   sample_type           rsp_sel_blue;

   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   int                   outstanding;
   int                   fail_count;

   // Idle knobs, changed per phase by the stimulus process
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   logic                 hold_off_pending = 1'b0;
   int                   quiet_cycles = 0;

   always #6 clock = ~clock;

   rgb_ratio_color_classifier uut (.*);

   color_result_checker result_check (.*);

   // Receiver: random stall, or one long hold-off when asked, so the block
   // fills and backs up the input while the sender keeps offering items.
   always begin
      @(posedge clock);
      if (hold_off_pending) begin
         rsp_stall <= 1'b1;
         repeat (HOLD_OFF_CYCLES) @(posedge clock);
         hold_off_pending = 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog: count cycles in which neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Mix of extremes, dim and bright levels so every class shows up
   function automatic sample_type pick_level();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         2:       return sample_type'($urandom_range(0, 31));
         3:       return sample_type'($urandom_range(900, 1023));
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Offer one item, with random idle cycles ahead of it; return at the
   // edge that accepts it, leaving valid high for a back-to-back item.
   task automatic offer_item(input logic kind, input sample_type red, green, blue);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_red_in   <= red;
      req_green_in <= green;
      req_blue_in  <= blue;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Drop valid and hold off until every expected result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (outstanding != 0);
   endtask

   // Write all six registers, plus the two unused indexes with junk
   task automatic write_config(input logic [CSR_DAT_W-1:0] bright, red, green, blue,
                               yellow, second);
      for (int idx = 0; idx < 8; idx++) begin
         csr_write <= 1'b1;
         csr_index <= CSR_IDX_W'(idx);
         case (CSR_IDX_W'(idx))
            CSR_BRIGHT: csr_data <= bright;
            CSR_RED:    csr_data <= red;
            CSR_GREEN:  csr_data <= green;
            CSR_BLUE:   csr_data <= blue;
            CSR_YELLOW: csr_data <= yellow;
            CSR_SECOND: csr_data <= second;
            default:    csr_data <= CSR_DAT_W'($urandom);
         endcase
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   // Directed items on the reset register values
   task automatic run_directed();
      // empty history: every divisor is zero, all ratios saturate
      offer_item(REQ_CLASSIFY, 10'd0, 10'd0, 10'd0);
      // full scale, then pushed until scaled blue reaches the oldest slot
      offer_item(REQ_CLASSIFY, 10'd1023, 10'd1023, 10'd1023);
      offer_item(REQ_CLASSIFY, 10'd1023, 10'd1023, 10'd1023);
      offer_item(REQ_CLASSIFY, 10'd1023, 10'd1023, 10'd1023);
      // restart entries carry unscaled blue into the oldest slot
      offer_item(REQ_RESTART, 10'd1023, 10'd1023, 10'd1023);
      offer_item(REQ_CLASSIFY, 10'd0, 10'd0, 10'd0);
      offer_item(REQ_CLASSIFY, 10'd0, 10'd0, 10'd0);
      // one clear case per color
      offer_item(REQ_RESTART, 10'd10, 10'd0, 10'd10);
      offer_item(REQ_CLASSIFY, 10'd0, 10'd900, 10'd0);
      offer_item(REQ_RESTART, 10'd900, 10'd0, 10'd20);
      offer_item(REQ_CLASSIFY, 10'd0, 10'd10, 10'd0);
      offer_item(REQ_RESTART, 10'd10, 10'd0, 10'd900);
      offer_item(REQ_CLASSIFY, 10'd0, 10'd10, 10'd0);
      offer_item(REQ_RESTART, 10'd600, 10'd0, 10'd10);
      offer_item(REQ_CLASSIFY, 10'd0, 10'd600, 10'd0);
      // green and yellow both saturate: green wins the tie
      offer_item(REQ_RESTART, 10'd900, 10'd0, 10'd0);
      offer_item(REQ_CLASSIFY, 10'd0, 10'd0, 10'd0);
      offer_item(REQ_RESTART, 10'd0, 10'd1023, 10'd0);
      offer_item(REQ_CLASSIFY, 10'd1023, 10'd0, 10'd1023);
      offer_item(REQ_CLASSIFY, 10'd512, 10'd341, 10'd682);
      offer_item(REQ_CLASSIFY, 10'd1, 10'd2, 10'd3);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         // registers only change with the block idle
         drain_results();
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (p)
            0:       write_config('0, '0, '0, '0, '0, '0);
            1:       write_config('1, '1, '1, '1, '1, '1);
            5:       write_config(CSR_DAT_W'($urandom), CSR_DAT_W'($urandom),
                                  CSR_DAT_W'($urandom), CSR_DAT_W'($urandom),
                                  CSR_DAT_W'($urandom), CSR_DAT_W'($urandom));
            default: write_config(CSR_DAT_W'($urandom_range(0, 600)),
                                  CSR_DAT_W'($urandom_range(0, 1536)),
                                  CSR_DAT_W'($urandom_range(0, 1536)),
                                  CSR_DAT_W'($urandom_range(0, 1536)),
                                  CSR_DAT_W'($urandom_range(0, 1536)),
                                  CSR_DAT_W'($urandom_range(0, 768)));
         endcase

         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 48;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 48;
            end
            default: begin
               send_idle_pct  = 17;
               recv_stall_pct = 17;
            end
         endcase

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == 10)
               hold_off_pending = 1'b1;
            // pause the sender mid-phase until the pipe is empty
            if (n == PHASE_ITEMS / 2)
               drain_results();
            offer_item(($urandom_range(99) < 15) ? REQ_RESTART : REQ_CLASSIFY,
                       pick_level(), pick_level(), pick_level());
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
